// ===== hw/rtl/crr_pkg.sv =====
// crr_pkg: shared constants, types and helper functions of the cubic resampler
// depends on nothing; used by crr_mac, crr_ctrl and the top level
package crr_pkg;

  // fixed point formats
  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned INT_BITS     = 32;
  localparam int unsigned POS_BITS     = INT_BITS + FRAC_BITS;
  localparam int unsigned MAX_UPSAMPLE = 16;
  localparam int unsigned CNT_BITS     = $clog2(MAX_UPSAMPLE + 1);

  // horner accumulator and product widths
  localparam int unsigned H_BITS    = SAMPLE_BITS + 7;
  localparam int unsigned PROD_BITS = H_BITS + FRAC_BITS + 1;

  // configuration registers
  localparam int unsigned RATIO_BITS = 20;
  localparam int unsigned START_BITS = 24;
  localparam int unsigned CFG_BITS   = 24;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(65536);
  localparam logic [START_BITS-1:0] START_RESET = '0;
  localparam logic [CNT_BITS-1:0]   CNT_MAX     = CNT_BITS'(MAX_UPSAMPLE);

  typedef enum logic {
    REG_RATIO = 1'b0,
    REG_START = 1'b1
  } reg_idx_e;

  // coefficient added after each horner multiply
  typedef enum logic [1:0] {
    COEF_B,
    COEF_C,
    COEF_D
  } coef_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_ACC,
    ST_ADV,
    ST_EMIT,
    ST_DONE
  } state_e;

  // sequencer commands to the arithmetic unit
  typedef struct packed {
    logic  shift;
    logic  clear;
    logic  load;
    logic  mul;
    logic  acc;
    coef_e coef;
  } mac_ctrl_t;

  // result beat produced by the sequencer
  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
  } emit_t;

  // sign extend a sample to accumulator width
  function automatic logic signed [H_BITS-1:0] sext_h(logic signed [SAMPLE_BITS-1:0] x);
    return {{(H_BITS - SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
  endfunction

  // saturate to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(logic signed [H_BITS-1:0] v);
    logic signed [H_BITS-1:0] hi;
    logic signed [H_BITS-1:0] lo;
    hi = {{(H_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    lo = {{(H_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end else begin
      return v[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/crr_mac.sv =====
// crr_mac: sample window, catmull-rom coefficients and the shared horner multiply-add unit
// depends on crr_pkg
module crr_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  crr_pkg::mac_ctrl_t                      ctrl_i,
  input  logic signed [crr_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic        [crr_pkg::FRAC_BITS-1:0]    frac_i,
  output logic signed [crr_pkg::SAMPLE_BITS-1:0]  value_o
);

  localparam logic signed [crr_pkg::PROD_BITS-1:0] HALF =
    crr_pkg::PROD_BITS'(1) << (crr_pkg::FRAC_BITS - 1);

  logic signed [crr_pkg::SAMPLE_BITS-1:0] win_q [4];
  logic signed [crr_pkg::H_BITS-1:0]      w0, w1, w2, w3;
  logic signed [crr_pkg::H_BITS-1:0]      a2, b2, c2, d2, coef;
  logic signed [crr_pkg::H_BITS-1:0]      h_q, h_d;
  logic signed [crr_pkg::PROD_BITS-1:0]   prod_q, prod_d;
  logic signed [crr_pkg::PROD_BITS-1:0]   rsum, rshift;
  logic signed [crr_pkg::FRAC_BITS:0]     frac_s;
  logic signed [crr_pkg::H_BITS-1:0]      hp1, half_h;

  // sample window, oldest in slot 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) win_q[i] <= '0;
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < 4; i++) win_q[i] <= '0;
    end else if (ctrl_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= sample_i;
    end
  end

  // doubled coefficients, exact integers
  always_comb begin
    w0 = crr_pkg::sext_h(win_q[0]);
    w1 = crr_pkg::sext_h(win_q[1]);
    w2 = crr_pkg::sext_h(win_q[2]);
    w3 = crr_pkg::sext_h(win_q[3]);
    a2 = w3 - w0 + (w1 <<< 1) + w1 - (w2 <<< 1) - w2;
    b2 = (w0 <<< 1) - (w1 <<< 2) - w1 + (w2 <<< 2) - w3;
    c2 = w2 - w0;
    d2 = w1 <<< 1;
  end

  // coefficient for the current horner step
  always_comb begin
    case (ctrl_i.coef)
      crr_pkg::COEF_B: coef = b2;
      crr_pkg::COEF_C: coef = c2;
      crr_pkg::COEF_D: coef = d2;
      default:         coef = d2;
    endcase
  end

  // multiply, then round to nearest and add
  always_comb begin
    frac_s = {1'b0, frac_i};
    prod_d = h_q * frac_s;
    rsum   = prod_q + HALF;
    rshift = rsum >>> crr_pkg::FRAC_BITS;
    h_d    = rshift[crr_pkg::H_BITS-1:0] + coef;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.load) begin
      h_q <= a2;
    end else if (ctrl_i.acc) begin
      h_q <= h_d;
    end
  end

  // halve with rounding and saturate
  always_comb begin
    hp1     = h_q + crr_pkg::H_BITS'(1);
    half_h  = hp1 >>> 1;
    value_o = crr_pkg::sat_sample(half_h);
  end

endmodule

// ===== hw/rtl/crr_ctrl.sv =====
// crr_ctrl: sequencer, configuration registers, output position and sample count
// depends on crr_pkg
module crr_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           clip_end_i,
  output logic                           in_ready_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [crr_pkg::CFG_BITS-1:0]   cfg_wdata_i,
  input  logic                           out_free_i,
  output crr_pkg::mac_ctrl_t             mac_ctrl_o,
  output logic [crr_pkg::FRAC_BITS-1:0]  frac_o,
  output crr_pkg::emit_t                 emit_o
);

  crr_pkg::state_e                 state_q, state_d;
  logic [crr_pkg::RATIO_BITS-1:0]  ratio_q;
  logic [crr_pkg::START_BITS-1:0]  start_q;
  logic [crr_pkg::POS_BITS-1:0]    pos_q;
  logic [crr_pkg::POS_BITS-1:0]    start_pos;
  logic [crr_pkg::INT_BITS-1:0]    rcv_q;
  logic [crr_pkg::INT_BITS-1:0]    target;
  logic [crr_pkg::CNT_BITS-1:0]    cnt_q;
  crr_pkg::coef_e                  step_q;
  logic                            clip_q;
  logic                            match, more, has_left;

  assign start_pos = {{(crr_pkg::INT_BITS - crr_pkg::START_BITS){1'b0}}, start_q,
                      {crr_pkg::FRAC_BITS{1'b0}}};
  assign target    = rcv_q - crr_pkg::INT_BITS'(2);
  assign match     = pos_q[crr_pkg::POS_BITS-1:crr_pkg::FRAC_BITS] == target;
  assign more      = (cnt_q < crr_pkg::CNT_MAX) && match;
  assign has_left  = rcv_q > crr_pkg::INT_BITS'(2);
  assign frac_o    = pos_q[crr_pkg::FRAC_BITS-1:0];

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    mac_ctrl_o      = '0;
    mac_ctrl_o.coef = step_q;
    emit_o          = '0;
    case (state_q)
      crr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mac_ctrl_o.shift = 1'b1;
          state_d          = crr_pkg::ST_CHECK;
        end
      end
      crr_pkg::ST_CHECK: begin
        if (more && has_left) begin
          mac_ctrl_o.load = 1'b1;
          state_d         = crr_pkg::ST_MUL;
        end else if (more) begin
          state_d = crr_pkg::ST_ADV;
        end else begin
          state_d = crr_pkg::ST_DONE;
        end
      end
      crr_pkg::ST_MUL: begin
        mac_ctrl_o.mul = 1'b1;
        state_d        = crr_pkg::ST_ACC;
      end
      crr_pkg::ST_ACC: begin
        mac_ctrl_o.acc = 1'b1;
        state_d = (step_q == crr_pkg::COEF_D) ? crr_pkg::ST_ADV : crr_pkg::ST_MUL;
      end
      crr_pkg::ST_ADV: begin
        state_d = crr_pkg::ST_EMIT;
      end
      crr_pkg::ST_EMIT: begin
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.last  = !more;
          emit_o.zero  = !has_left;
          if (more && has_left) begin
            mac_ctrl_o.load = 1'b1;
            state_d         = crr_pkg::ST_MUL;
          end else if (more) begin
            state_d = crr_pkg::ST_ADV;
          end else begin
            state_d = crr_pkg::ST_DONE;
          end
        end
      end
      crr_pkg::ST_DONE: begin
        mac_ctrl_o.clear = clip_q;
        state_d          = crr_pkg::ST_IDLE;
      end
      default: begin
        state_d = crr_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration, position and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= crr_pkg::RATIO_RESET;
      start_q <= crr_pkg::START_RESET;
      pos_q   <= '0;
      rcv_q   <= '0;
      cnt_q   <= '0;
      step_q  <= crr_pkg::COEF_B;
      clip_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == crr_pkg::REG_RATIO) begin
        ratio_q <= cfg_wdata_i[crr_pkg::RATIO_BITS-1:0];
      end
      if (cfg_we_i && cfg_index_i == crr_pkg::REG_START) begin
        start_q <= cfg_wdata_i[crr_pkg::START_BITS-1:0];
        if (rcv_q == '0) begin
          pos_q <= {{(crr_pkg::INT_BITS - crr_pkg::START_BITS){1'b0}},
                    cfg_wdata_i[crr_pkg::START_BITS-1:0], {crr_pkg::FRAC_BITS{1'b0}}};
        end
      end
      if (in_ready_o && in_valid_i) begin
        cnt_q  <= '0;
        clip_q <= clip_end_i;
      end
      if (mac_ctrl_o.load) begin
        step_q <= crr_pkg::COEF_B;
      end else if (mac_ctrl_o.acc) begin
        case (step_q)
          crr_pkg::COEF_B: step_q <= crr_pkg::COEF_C;
          crr_pkg::COEF_C: step_q <= crr_pkg::COEF_D;
          default:         step_q <= crr_pkg::COEF_B;
        endcase
      end
      if (state_q == crr_pkg::ST_ADV) begin
        pos_q <= pos_q + {{(crr_pkg::POS_BITS - crr_pkg::RATIO_BITS){1'b0}}, ratio_q};
        cnt_q <= cnt_q + crr_pkg::CNT_BITS'(1);
      end
      if (state_q == crr_pkg::ST_DONE) begin
        if (clip_q) begin
          rcv_q <= '0;
          pos_q <= start_pos;
        end else begin
          rcv_q <= rcv_q + crr_pkg::INT_BITS'(1);
          // too many outputs for one sample: skip to the next integer part
          if (cnt_q == crr_pkg::CNT_MAX && match) begin
            pos_q <= {target + crr_pkg::INT_BITS'(1), {crr_pkg::FRAC_BITS{1'b0}}};
          end
        end
      end
    end
  end

  // a result beat only when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> out_free_i)
    else $error("result beat issued while output register busy");

  // result count per sample stays within the upsampling limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= crr_pkg::CNT_MAX)
    else $error("result count beyond limit");

  // a non-final result is always followed by more work for the same sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && !emit_o.last) |=> (state_q == crr_pkg::ST_MUL ||
                                         state_q == crr_pkg::ST_ADV))
    else $error("run ended without final result flag");

  // no new sample while the previous one still has results to produce
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && !emit_o.last) |=> !in_ready_o)
    else $error("input accepted mid run");

endmodule

// ===== hw/rtl/catmull_rom_cubic_resampler_top.sv =====
// catmull_rom_cubic_resampler_top: streaming catmull-rom cubic resampler, top level
// depends on crr_pkg, crr_mac and crr_ctrl
//
//   channel   signals                              dir   beat
//   -------   ----------------------------------   ---   -------------------------------
//   in        in_valid_i in_ready_o sample_i         in    one source sample
//             clip_end_i
//   out       out_valid_o out_ready_i value_o       out   one interpolated sample
//             run_end_o
//   cfg       cfg_we_i cfg_index_i cfg_wdata_i       in    register write, no wait
//
// a sample yields up to 16 interpolated results; for each, the one shared multiplier
// runs three horner steps, a multiply then an accumulate each, followed by position
// advance and issue (a result with no left neighbour takes only advance and issue).
// in_ready_o is high only while the sequencer is idle.
// a busy output register stalls the sequencer at result issue; the last result
// may still wait in the output register while the next sample is taken.
// reset is asynchronous, active low; no clearing pass is needed.
module catmull_rom_cubic_resampler_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [crr_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                                    clip_end_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [crr_pkg::SAMPLE_BITS-1:0]  value_o,
  output logic                                    run_end_o,
  input  logic                                    cfg_we_i,
  input  logic                                    cfg_index_i,
  input  logic        [crr_pkg::CFG_BITS-1:0]     cfg_wdata_i
);

  crr_pkg::mac_ctrl_t                     mac_ctrl;
  crr_pkg::emit_t                         emit;
  logic [crr_pkg::FRAC_BITS-1:0]          frac;
  logic signed [crr_pkg::SAMPLE_BITS-1:0] mac_value;
  logic                                   out_free;
  logic                                   out_valid_q;
  logic signed [crr_pkg::SAMPLE_BITS-1:0] value_q;
  logic                                   run_end_q;

  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  crr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .clip_end_i  (clip_end_i),
    .in_ready_o  (in_ready_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_free_i  (out_free),
    .mac_ctrl_o  (mac_ctrl),
    .frac_o      (frac),
    .emit_o      (emit)
  );

  // shared arithmetic unit
  crr_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (sample_i),
    .frac_i   (frac),
    .value_o  (mac_value)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      value_q   <= emit.zero ? '0 : mac_value;
      run_end_q <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign run_end_o   = run_end_q;

endmodule
